// ===== rtl/pli_pkg.sv =====
package pli_pkg;

    // List depth and derived widths.
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int ECNT_W = 5;
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Status codes.
    localparam logic [STAT_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BAD_POS = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd2;

    // Broadcast from the control logic to every cell of the row.
    typedef struct packed {
        logic                     wr_en;
        logic                     op;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } pli_ctrl_t;

endpackage

// ===== rtl/pli_cell.sv =====
module pli_cell (
    input  logic                              clk,
    input  logic [pli_pkg::IDX_W-1:0]         cell_index,
    input  pli_pkg::pli_ctrl_t                ctrl,
    input  logic signed [pli_pkg::DATA_W-1:0] left_entry,
    input  logic signed [pli_pkg::DATA_W-1:0] right_entry,
    output logic signed [pli_pkg::DATA_W-1:0] entry
);

    logic signed [pli_pkg::DATA_W-1:0] entry_reg;
    logic signed [pli_pkg::DATA_W-1:0] entry_next;
    logic [pli_pkg::CMP_W-1:0]         slot;
    logic [pli_pkg::CMP_W-1:0]         pos_ext;

    // This cell's 1-based place in the list, and the requested position.
    assign slot    = pli_pkg::CMP_W'(cell_index) + pli_pkg::CMP_W'(1);
    assign pos_ext = pli_pkg::CMP_W'(ctrl.position);

    // An insert takes the new value at the position and the left neighbor
    // past it; a delete takes the right neighbor from the position onward.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.wr_en)
        begin
            if (ctrl.op == pli_pkg::OP_INSERT)
            begin
                if (slot == pos_ext)
                begin
                    entry_next = ctrl.value;
                end
                else if (slot > pos_ext)
                begin
                    entry_next = left_entry;
                end
            end
            else if (slot >= pos_ext)
            begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/positional_list_insert_delete.sv =====
// Results are registered: a result beat appears in the cycle after its item beat is accepted.
// Throughput: one item per cycle; every cell of the row shifts in the same
// cycle, so the item rate is set only by the output register being free.
// Reset: rst_n clears the entry count and the output valid; the cell
// contents are not reset and are written before they are ever read.
module positional_list_insert_delete (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic                              opcode,
    input  logic [pli_pkg::POS_W-1:0]         position,
    input  logic signed [pli_pkg::DATA_W-1:0] value,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [pli_pkg::STAT_W-1:0]        status,
    output logic signed [pli_pkg::DATA_W-1:0] removed_value,
    output logic [pli_pkg::ECNT_W-1:0]        entry_count
);

    logic                              accept;
    pli_pkg::pli_ctrl_t                ctrl;
    logic signed [pli_pkg::DATA_W-1:0] cell_entry [pli_pkg::DEPTH];

    logic [pli_pkg::CNT_W-1:0]         count_reg;
    logic [pli_pkg::CNT_W-1:0]         count_next;
    logic                              valid_reg;
    logic [pli_pkg::STAT_W-1:0]        status_reg;
    logic [pli_pkg::STAT_W-1:0]        status_next;
    logic signed [pli_pkg::DATA_W-1:0] removed_reg;
    logic signed [pli_pkg::DATA_W-1:0] removed_next;
    logic [pli_pkg::ECNT_W-1:0]        ecount_reg;

    logic [pli_pkg::CMP_W-1:0]         pos_ext;
    logic [pli_pkg::CMP_W-1:0]         cnt_ext;
    logic [pli_pkg::CMP_W-1:0]         sel;

    // A new item enters whenever the output register is empty or draining.
    assign item_ready = !valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    assign pos_ext = pli_pkg::CMP_W'(position);
    assign cnt_ext = pli_pkg::CMP_W'(count_reg);
    assign sel     = pos_ext - pli_pkg::CMP_W'(1);

    // Range and capacity checks, new count and the removed entry.
    always_comb
    begin
        status_next  = pli_pkg::STATUS_DONE;
        removed_next = '0;
        count_next   = count_reg;
        if (opcode == pli_pkg::OP_INSERT)
        begin
            if (pos_ext == '0 || pos_ext > cnt_ext + pli_pkg::CMP_W'(1))
            begin
                status_next = pli_pkg::STATUS_BAD_POS;
            end
            else if (cnt_ext >= pli_pkg::CMP_W'(pli_pkg::DEPTH))
            begin
                status_next = pli_pkg::STATUS_FULL;
            end
            else
            begin
                count_next = count_reg + pli_pkg::CNT_W'(1);
            end
        end
        else
        begin
            if (pos_ext == '0 || pos_ext > cnt_ext)
            begin
                status_next = pli_pkg::STATUS_BAD_POS;
            end
            else
            begin
                removed_next = cell_entry[sel[pli_pkg::IDX_W-1:0]];
                count_next   = count_reg - pli_pkg::CNT_W'(1);
            end
        end
    end

    // Broadcast to the row of cells.
    always_comb
    begin
        ctrl.wr_en    = accept && (status_next == pli_pkg::STATUS_DONE);
        ctrl.op       = opcode;
        ctrl.position = position;
        ctrl.value    = value;
    end

    // The row of cells; each hands its entry to both neighbors.
    genvar gi;
    generate
        for (gi = 0; gi < pli_pkg::DEPTH; gi++)
        begin : g_cell
            logic signed [pli_pkg::DATA_W-1:0] left_in;
            logic signed [pli_pkg::DATA_W-1:0] right_in;

            if (gi == 0)
            begin : g_first
                assign left_in = value;
            end
            else
            begin : g_mid_l
                assign left_in = cell_entry[gi-1];
            end

            if (gi == pli_pkg::DEPTH - 1)
            begin : g_last
                assign right_in = '0;
            end
            else
            begin : g_mid_r
                assign right_in = cell_entry[gi+1];
            end

            pli_cell u_cell (
                .clk         (clk),
                .cell_index  (pli_pkg::IDX_W'(gi)),
                .ctrl        (ctrl),
                .left_entry  (left_in),
                .right_entry (right_in),
                .entry       (cell_entry[gi])
            );
        end
    endgenerate

    // Entry count and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
                valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            ecount_reg  <= pli_pkg::ECNT_W'(pli_pkg::CMP_W'(count_next));
        end
    end

    assign result_valid  = valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign entry_count   = ecount_reg;

    // The list never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        pli_pkg::CMP_W'(count_reg) <= pli_pkg::CMP_W'(pli_pkg::DEPTH))
        else $error("entry count above depth");

    // A good insert grows the list by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && opcode == pli_pkg::OP_INSERT && status_next == pli_pkg::STATUS_DONE
        |=> pli_pkg::CMP_W'(count_reg) == pli_pkg::CMP_W'($past(count_reg)) + pli_pkg::CMP_W'(1))
        else $error("insert did not grow the list");

    // A rejected item leaves the count alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && status_next != pli_pkg::STATUS_DONE |=> $stable(count_reg))
        else $error("rejected item changed the count");

    // Every accepted item leaves a result beat behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> valid_reg)
        else $error("accepted item gave no result");

endmodule

// ===== bench/positional_list_insert_delete_tb.sv =====
`timescale 1ns / 1ps

module positional_list_insert_delete_tb;

    localparam int RANDOM_ITEMS = 1250;
    localparam int QUIET_TAIL   = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 80;

    // One pending command for the list.
    typedef struct {
        logic                              op;
        logic [pli_pkg::POS_W-1:0]         pos;
        logic signed [pli_pkg::DATA_W-1:0] val;
        bit                                drain;
    } list_cmd_t;

    // One expected result beat.
    typedef struct {
        logic [pli_pkg::STAT_W-1:0]        status;
        logic signed [pli_pkg::DATA_W-1:0] removed;
        logic [pli_pkg::ECNT_W-1:0]        count;
    } list_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              item_valid = 1'b0;
    logic                              item_ready;
    logic                              opcode = pli_pkg::OP_INSERT;
    logic [pli_pkg::POS_W-1:0]         position = '0;
    logic signed [pli_pkg::DATA_W-1:0] value = '0;
    logic                              result_valid;
    logic                              result_ready = 1'b0;
    logic [pli_pkg::STAT_W-1:0]        status;
    logic signed [pli_pkg::DATA_W-1:0] removed_value;
    logic [pli_pkg::ECNT_W-1:0]        entry_count;

    list_cmd_t    pending_cmds[$];
    list_result_t expected_results[$];

    // Predicted list contents and length.
    logic signed [pli_pkg::DATA_W-1:0] shadow_cells [pli_pkg::DEPTH];
    int unsigned                       shadow_len = 0;

    // Length of the list as the stimulus generator sees it.
    int unsigned gen_len = 0;

    int  accepted_items = 0;
    int  driven_items = 0;
    int  results_seen = 0;
    int  mismatch_count = 0;
    int  idle_cycles = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    bit  long_hold_done = 1'b0;

    positional_list_insert_delete uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .opcode        (opcode),
        .position      (position),
        .value         (value),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .status        (status),
        .removed_value (removed_value),
        .entry_count   (entry_count)
    );

    always #2 clk = ~clk;

    // Applies one command to the shadow list and returns the result it gives.
    function automatic list_result_t apply_list_op(
        logic                              op,
        logic [pli_pkg::POS_W-1:0]         pos,
        logic signed [pli_pkg::DATA_W-1:0] val
    );
        list_result_t r;
        int unsigned  p;
        r.status  = pli_pkg::STATUS_DONE;
        r.removed = '0;
        p = pos;
        if (op == pli_pkg::OP_INSERT)
        begin
            if (p < 1 || p > shadow_len + 1)
                r.status = pli_pkg::STATUS_BAD_POS;
            else if (shadow_len >= pli_pkg::DEPTH)
                r.status = pli_pkg::STATUS_FULL;
            else
            begin
                for (int i = shadow_len; i > p - 1; i--)
                    shadow_cells[i] = shadow_cells[i - 1];
                shadow_cells[p - 1] = val;
                shadow_len++;
            end
        end
        else
        begin
            if (p < 1 || p > shadow_len)
                r.status = pli_pkg::STATUS_BAD_POS;
            else
            begin
                r.removed = shadow_cells[p - 1];
                for (int i = p - 1; i + 1 < shadow_len; i++)
                    shadow_cells[i] = shadow_cells[i + 1];
                shadow_len--;
            end
        end
        r.count = shadow_len[pli_pkg::ECNT_W-1:0];
        return r;
    endfunction

    // Queues a command and tracks the list length it will leave behind.
    task automatic push_cmd(
        logic                              op,
        int unsigned                       pos,
        logic signed [pli_pkg::DATA_W-1:0] val,
        bit                                drain
    );
        list_cmd_t c;
        c.op    = op;
        c.pos   = pos[pli_pkg::POS_W-1:0];
        c.val   = val;
        c.drain = drain;
        pending_cmds.push_back(c);
        if (op == pli_pkg::OP_INSERT)
        begin
            if (pos >= 1 && pos <= gen_len + 1 && gen_len < pli_pkg::DEPTH)
                gen_len++;
        end
        else if (pos >= 1 && pos <= gen_len)
            gen_len--;
    endtask

    // Item side: present the next command once the current beat is taken.
    always @(negedge clk)
    begin
        if (rst_n && accepted_items == driven_items)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (pending_cmds.size() == 0)
                item_valid <= 1'b0;
            else if (pending_cmds[0].drain && expected_results.size() != 0)
                item_valid <= 1'b0;
            else
            begin
                opcode   <= pending_cmds[0].op;
                position <= pending_cmds[0].pos;
                value    <= pending_cmds[0].val;
                item_valid <= 1'b1;
                void'(pending_cmds.pop_front());
                driven_items++;
                // Sometimes leave a gap after this beat.
                if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 17);
            end
        end
    end

    // Result side: random stalls, plus one long hold-off to back the block up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_gap > 0)
            begin
                recv_gap--;
                result_ready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= 300)
            begin
                long_hold_done = 1'b1;
                recv_gap = LONG_HOLD - 1;
                result_ready <= 1'b0;
            end
            else if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(1, 17) - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Monitor: predict on each item beat, check each result beat, watch for a hang.
    always @(posedge clk)
    begin : monitor
        list_result_t exp_r;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result beat with nothing expected (status %0d)",
                             $time, status);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (status !== exp_r.status)
                    begin
                        mismatch_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, status);
                    end
                    if (removed_value !== exp_r.removed)
                    begin
                        mismatch_count++;
                        $display("%0t: removed_value expected %0d actual %0d",
                                 $time, exp_r.removed, removed_value);
                    end
                    if (entry_count !== exp_r.count)
                    begin
                        mismatch_count++;
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, exp_r.count, entry_count);
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                accepted_items++;
                expected_results.push_back(apply_list_op(opcode, position, value));
            end
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin : stimulus
        int unsigned                       ins_pct;
        int unsigned                       pos;
        logic                              op;
        logic signed [pli_pkg::DATA_W-1:0] val;

        // Directed: bad positions on an empty list, extreme values, ends and middle.
        push_cmd(pli_pkg::OP_INSERT, 0, 32'sd5, 1'b0);
        push_cmd(pli_pkg::OP_DELETE, 1, 32'sd0, 1'b0);
        push_cmd(pli_pkg::OP_INSERT, 1, 32'sh7fffffff, 1'b0);
        push_cmd(pli_pkg::OP_INSERT, 1, 32'sh80000000, 1'b0);
        push_cmd(pli_pkg::OP_INSERT, 3, -32'sd1, 1'b0);
        push_cmd(pli_pkg::OP_INSERT, 2, 32'sd0, 1'b0);
        push_cmd(pli_pkg::OP_INSERT, 6, 32'sd9, 1'b0);
        push_cmd(pli_pkg::OP_DELETE, 4, 32'sd7, 1'b0);
        push_cmd(pli_pkg::OP_DELETE, 1, 32'sd0, 1'b0);
        push_cmd(pli_pkg::OP_DELETE, 0, 32'sd0, 1'b0);
        push_cmd(pli_pkg::OP_DELETE, 31, 32'sd0, 1'b0);
        // Fill the list to the top.
        while (gen_len < pli_pkg::DEPTH)
            push_cmd(pli_pkg::OP_INSERT, gen_len + 1, $urandom, 1'b0);
        // Full list, then a bad position on a full list, then the deepest delete.
        push_cmd(pli_pkg::OP_INSERT, 8, 32'sd1, 1'b0);
        push_cmd(pli_pkg::OP_INSERT, 18, 32'sd1, 1'b0);
        push_cmd(pli_pkg::OP_DELETE, pli_pkg::DEPTH, 32'sd0, 1'b0);

        // Random part: stretches that lean toward filling or draining the list.
        ins_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 125 == 0)
                ins_pct = $urandom_range(15, 85);
            val = $urandom;
            if ($urandom_range(0, 19) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: val = 32'sh7fffffff;
                    1: val = 32'sh80000000;
                    2: val = 32'sd0;
                    default: val = -32'sd1;
                endcase
            end
            if ($urandom_range(0, 99) < 8)
            begin
                op  = 1'($urandom_range(0, 1));
                pos = $urandom_range(0, 31);
            end
            else if ($urandom_range(0, 99) < ins_pct)
            begin
                op  = pli_pkg::OP_INSERT;
                pos = $urandom_range(1, gen_len + 1);
            end
            else
            begin
                op  = pli_pkg::OP_DELETE;
                pos = (gen_len == 0) ? 1 : $urandom_range(1, gen_len);
            end
            push_cmd(op, pos, val, n == RANDOM_ITEMS / 2);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every command to go in and every result to come back.
        while (pending_cmds.size() != 0 || item_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
